// File: rtl/core/rc5_block_cipher_defines.svh
// Assertion macros for the RC5 block cipher checker.
// Included by the checker file only; depends on nothing else.
`ifndef RC5_BLOCK_CIPHER_DEFINES_SVH
`define RC5_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RC5_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RC5_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rc5_pkg.sv
// Shared types, constants and helper functions of the RC5 block cipher.
// Used by the interfaces, the controller, the datapath and the top level.
package rc5_pkg;

  // Cipher geometry.
  localparam int unsigned ROUNDS   = 12;
  localparam int unsigned WordW    = 32;
  localparam int unsigned RotW     = $clog2(WordW);
  localparam int unsigned KeyHalfW = 64;
  localparam int unsigned Rows     = ROUNDS + 1;
  localparam int unsigned TabDepth = 2 * Rows;
  localparam int unsigned RowW     = $clog2(Rows);
  localparam int unsigned TabW     = $clog2(TabDepth);
  localparam int unsigned KeyWords = 4;
  localparam int unsigned KwW      = $clog2(KeyWords);
  localparam int unsigned Passes   = 3;
  localparam int unsigned PassW    = $clog2(Passes);

  typedef logic [WordW-1:0]    word_t;
  typedef logic [KeyHalfW-1:0] key_half_t;
  typedef logic [1:0]          op_t;
  typedef logic [RowW-1:0]     row_t;
  typedef logic [TabW-1:0]     tab_t;
  typedef logic [KwW-1:0]      kw_idx_t;
  typedef logic [PassW-1:0]    pass_t;
  typedef logic [RotW-1:0]     rot_t;
  typedef logic [0:0]          cfg_idx_t;

  // Magic constants of the key schedule.
  localparam word_t MagicP = 32'hb7e15163;
  localparam word_t MagicQ = 32'h9e3779b9;
  localparam rot_t  MixRot = rot_t'(3);

  // Configuration register indexes.
  localparam cfg_idx_t CfgKeyLow  = 1'b0;
  localparam cfg_idx_t CfgKeyHigh = 1'b1;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_EXPAND  = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CIPHER,
    ST_MIX_A,
    ST_MIX_B,
    ST_DONE
  } state_e;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_EXPAND,
    DP_ENC_WHITE,
    DP_ENC_ROUND,
    DP_DEC_ROUND,
    DP_DEC_WHITE,
    DP_MIX_A,
    DP_MIX_B
  } dp_op_e;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    dp_op_e  op;
    logic    ld_out;
    row_t    rd_row;
    tab_t    tab_idx;
    kw_idx_t kw_idx;
    logic    seed;
  } cmd_t;

  // Seed values of the round-key table: P + i*Q, built at elaboration.
  typedef word_t seed_tab_t [TabDepth];

  function automatic seed_tab_t build_seed_tab();
    seed_tab_t tab;
    tab[0] = MagicP;
    for (int i = 1; i < TabDepth; i++) begin
      tab[i] = tab[i-1] + MagicQ;
    end
    return tab;
  endfunction

  localparam seed_tab_t SeedTab = build_seed_tab();

  // Rotate left by the low bits of the amount.
  function automatic word_t rotl(word_t x, rot_t n);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WordW-1:WordW];
  endfunction

  // Rotate right by the low bits of the amount.
  function automatic word_t rotr(word_t x, rot_t n);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[WordW-1:0];
  endfunction

endpackage

// File: rtl/core/rc5_if.sv
// Valid/ready channel interfaces of the RC5 block cipher: input items,
// result items and configuration writes. Depends on rc5_pkg.
interface rc5_in_if;
  import rc5_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  word_t data_a;
  word_t data_b;

  modport source (output valid, output operation, output data_a, output data_b,
                  input ready);
  modport sink   (input valid, input operation, input data_a, input data_b,
                  output ready);
endinterface

interface rc5_out_if;
  import rc5_pkg::*;

  logic  valid;
  logic  ready;
  word_t result_a;
  word_t result_b;

  modport source (output valid, output result_a, output result_b, input ready);
  modport sink   (input valid, input result_a, input result_b, output ready);
endinterface

interface rc5_cfg_if;
  import rc5_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  key_half_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rc5_block_cipher.sv
// Top level of the RC5-32/12/16 block cipher.
// Depends on rc5_pkg, the channel interfaces, rc5_ctrl and rc5_dp.
//
// Usage:
//   cfg_i writes the key: index 0 holds key bytes 0..7, index 1 bytes 8..15,
//   byte i at bits 8i+7..8i. It is always ready; write it only while idle.
//   item_in_i takes one item at a time: operation 0 expands the key into the
//   round-key table, 1 encrypts and 2 decrypts the block data_a/data_b.
//   result_o returns one item per input item: the processed block, or zero
//   for expand and for the unused operation code.
// Sequence:
//   Encrypt and decrypt, from accept to the next accept: the accept state
//   fetches the first round keys, the shared round unit does the whitening
//   and 12 rounds, and the done state loads the output register.
//   Expand runs 78 mixing steps on the round-key memory port, each in a
//   mix-A and a mix-B state, plus the accept and output states.
// Reset clears the controller, the key registers and the written flags of the round-key table.
// If the receiver stalls, one finished result waits in the output register
// while the next item is accepted and worked on; that item then waits in
// its final state until the output register is free.
module rc5_block_cipher (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc5_cfg_if.sink   cfg_i,
  rc5_in_if.sink    item_in_i,
  rc5_out_if.source result_o
);
  import rc5_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign cfg_i.ready     = 1'b1;
  assign item_in_i.ready = in_ready;
  assign result_o.valid  = out_valid;

  // Sequencer.
  rc5_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in_i.valid),
    .in_ready_o  (in_ready),
    .op_i        (item_in_i.operation),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  // Key storage, round unit and result register.
  rc5_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid && cfg_i.ready),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .data_a_i    (item_in_i.data_a),
    .data_b_i    (item_in_i.data_b),
    .cmd_i       (cmd),
    .result_a_o  (result_o.result_a),
    .result_b_o  (result_o.result_b)
  );

endmodule

// File: rtl/core/rc5_ctrl.sv
// Controller of the RC5 block cipher: sequences cipher rounds and key
// expansion steps and drives the datapath through rc5_pkg::cmd_t.
module rc5_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rc5_pkg::op_t  op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rc5_pkg::cmd_t cmd_o
);
  import rc5_pkg::*;

  localparam row_t  LastRow  = row_t'(ROUNDS);
  localparam tab_t  LastTab  = tab_t'(TabDepth - 1);
  localparam pass_t LastPass = pass_t'(Passes - 1);

  state_e  state_q, state_d;
  row_t    row_q, row_d;
  logic    dec_q, dec_d;
  tab_t    tab_q, tab_d;
  kw_idx_t kw_q, kw_d;
  pass_t   pass_q, pass_d;
  logic    out_vld_q, out_vld_d;

  logic accept;
  logic cipher_last;
  logic exp_last;
  logic out_free;
  tab_t tab_nxt;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign cipher_last = dec_q ? (row_q == '0) : (row_q == LastRow);
  assign tab_nxt     = (tab_q == LastTab) ? '0 : tab_q + 1'b1;
  assign exp_last    = (pass_q == LastPass) && (tab_q == LastTab);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i) inside
            OP_EXPAND:              state_d = ST_MIX_A;
            OP_ENCRYPT, OP_DECRYPT: state_d = ST_CIPHER;
            default:                state_d = ST_DONE;
          endcase
        end
      end
      ST_CIPHER: begin
        if (cipher_last) state_d = ST_DONE;
      end
      ST_MIX_A: state_d = ST_MIX_B;
      ST_MIX_B: begin
        state_d = exp_last ? ST_DONE : ST_MIX_A;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command and counter logic.
  always_comb begin
    cmd_o.op      = DP_NOP;
    cmd_o.ld_out  = 1'b0;
    cmd_o.rd_row  = '0;
    cmd_o.tab_idx = tab_q;
    cmd_o.kw_idx  = kw_q;
    cmd_o.seed    = (pass_q == '0);
    row_d         = row_q;
    dec_d         = dec_q;
    tab_d         = tab_q;
    kw_d          = kw_q;
    pass_d        = pass_q;
    out_vld_d     = out_vld_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_EXPAND: begin
              cmd_o.op = DP_EXPAND;
              tab_d    = '0;
              kw_d     = '0;
              pass_d   = '0;
            end
            OP_ENCRYPT: begin
              cmd_o.op     = DP_LOAD;
              cmd_o.rd_row = '0;
              row_d        = '0;
              dec_d        = 1'b0;
            end
            OP_DECRYPT: begin
              cmd_o.op     = DP_LOAD;
              cmd_o.rd_row = LastRow;
              row_d        = LastRow;
              dec_d        = 1'b1;
            end
            default: cmd_o.op = DP_CLEAR;
          endcase
        end
      end
      ST_CIPHER: begin
        // Row zero holds the whitening keys: first for encrypt, last for decrypt.
        if (dec_q) begin
          cmd_o.op = (row_q == '0) ? DP_DEC_WHITE : DP_DEC_ROUND;
        end else begin
          cmd_o.op = (row_q == '0) ? DP_ENC_WHITE : DP_ENC_ROUND;
        end
        // Fetch the keys of the next round while the current round runs.
        if (cipher_last) begin
          cmd_o.rd_row = row_q;
        end else if (dec_q) begin
          cmd_o.rd_row = row_q - 1'b1;
        end else begin
          cmd_o.rd_row = row_q + 1'b1;
        end
        row_d = cmd_o.rd_row;
      end
      ST_MIX_A: cmd_o.op = DP_MIX_A;
      ST_MIX_B: begin
        cmd_o.op     = DP_MIX_B;
        cmd_o.rd_row = tab_nxt[TabW-1:1];
        tab_d        = tab_nxt;
        kw_d         = kw_q + 1'b1;
        if (tab_q == LastTab) pass_d = pass_q + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          out_vld_d    = 1'b1;
        end
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      dec_q     <= 1'b0;
      tab_q     <= '0;
      kw_q      <= '0;
      pass_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      dec_q     <= dec_d;
      tab_q     <= tab_d;
      kw_q      <= kw_d;
      pass_q    <= pass_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: rtl/core/rc5_dp.sv
// Datapath of the RC5 block cipher: key registers, round-key memory banks,
// key-schedule state, the shared round unit and the result register.
// Depends on rc5_pkg; driven by rc5_ctrl through rc5_pkg::cmd_t.
module rc5_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  rc5_pkg::cfg_idx_t  cfg_index_i,
  input  rc5_pkg::key_half_t cfg_data_i,
  input  rc5_pkg::word_t     data_a_i,
  input  rc5_pkg::word_t     data_b_i,
  input  rc5_pkg::cmd_t      cmd_i,
  output rc5_pkg::word_t     result_a_o,
  output rc5_pkg::word_t     result_b_o
);
  import rc5_pkg::*;

  // Configuration and key-schedule state.
  key_half_t key_lo_q, key_hi_q;
  word_t     kw_q [KeyWords];
  word_t     mix_a_q, mix_b_q;

  // Round-key banks: even entries in one, odd entries in the other, one row per round plus the whitening row.
  word_t           mem_e [Rows];
  word_t           mem_o [Rows];
  logic [Rows-1:0] vld_e_q, vld_o_q;
  word_t           rd_e_q, rd_o_q;
  logic            rd_ve_q, rd_vo_q;

  // Block registers and result register.
  word_t a_q, a_d, b_q, b_d;
  word_t res_a_q, res_b_q;

  word_t e_w, o_w;
  word_t enc_a, enc_b, dec_a, dec_b;
  word_t mix_sum, s_w, mix_a_new, mix_b_new;
  logic  tab_wr;
  row_t  wr_row;

  // Entries never written since reset read as zero.
  assign e_w = rd_ve_q ? rd_e_q : '0;
  assign o_w = rd_vo_q ? rd_o_q : '0;

  // One full encrypt or decrypt round.
  assign enc_a = rotl(a_q ^ b_q, rot_t'(b_q[RotW-1:0])) + e_w;
  assign enc_b = rotl(b_q ^ enc_a, rot_t'(enc_a[RotW-1:0])) + o_w;
  assign dec_b = rotr(b_q - o_w, rot_t'(a_q[RotW-1:0])) ^ a_q;
  assign dec_a = rotr(a_q - e_w, rot_t'(dec_b[RotW-1:0])) ^ dec_b;

  // Key-schedule mixing step, split over the mix-A and mix-B states.
  assign mix_sum   = mix_a_q + mix_b_q;
  assign s_w       = cmd_i.seed ? SeedTab[cmd_i.tab_idx] :
                     (cmd_i.tab_idx[0] ? o_w : e_w);
  assign mix_a_new = rotl(s_w + mix_sum, MixRot);
  assign mix_b_new = rotl(kw_q[cmd_i.kw_idx] + mix_sum, rot_t'(mix_sum[RotW-1:0]));

  assign tab_wr = (cmd_i.op == DP_MIX_A);
  assign wr_row = cmd_i.tab_idx[TabW-1:1];

  // Key registers, written through the configuration channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        default:    key_lo_q <= key_lo_q;
      endcase
    end
  end

  // Key words and mixing registers of the key schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) kw_q[i] <= '0;
      mix_a_q <= '0;
      mix_b_q <= '0;
    end else begin
      case (cmd_i.op)
        DP_EXPAND: begin
          kw_q[0] <= key_lo_q[WordW-1:0];
          kw_q[1] <= key_lo_q[KeyHalfW-1:WordW];
          kw_q[2] <= key_hi_q[WordW-1:0];
          kw_q[3] <= key_hi_q[KeyHalfW-1:WordW];
          mix_a_q <= '0;
          mix_b_q <= '0;
        end
        DP_MIX_A: mix_a_q <= mix_a_new;
        DP_MIX_B: begin
          mix_b_q             <= mix_b_new;
          kw_q[cmd_i.kw_idx] <= mix_b_new;
        end
        default: mix_a_q <= mix_a_q;
      endcase
    end
  end

  // Round-key banks: one write and one registered read per bank and cycle.
  always_ff @(posedge clk_i) begin
    if (tab_wr && !cmd_i.tab_idx[0]) mem_e[wr_row] <= mix_a_new;
    if (tab_wr && cmd_i.tab_idx[0])  mem_o[wr_row] <= mix_a_new;
    rd_e_q <= mem_e[cmd_i.rd_row];
    rd_o_q <= mem_o[cmd_i.rd_row];
  end

  // Written flags of the banks, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= '0;
      vld_o_q <= '0;
      rd_ve_q <= 1'b0;
      rd_vo_q <= 1'b0;
    end else begin
      if (tab_wr && !cmd_i.tab_idx[0]) vld_e_q[wr_row] <= 1'b1;
      if (tab_wr && cmd_i.tab_idx[0])  vld_o_q[wr_row] <= 1'b1;
      rd_ve_q <= vld_e_q[cmd_i.rd_row];
      rd_vo_q <= vld_o_q[cmd_i.rd_row];
    end
  end

  // Block word update for the current operation.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    case (cmd_i.op) inside
      DP_LOAD: begin
        a_d = data_a_i;
        b_d = data_b_i;
      end
      DP_CLEAR, DP_EXPAND: begin
        a_d = '0;
        b_d = '0;
      end
      DP_ENC_WHITE: begin
        a_d = a_q + e_w;
        b_d = b_q + o_w;
      end
      DP_ENC_ROUND: begin
        a_d = enc_a;
        b_d = enc_b;
      end
      DP_DEC_ROUND: begin
        a_d = dec_a;
        b_d = dec_b;
      end
      DP_DEC_WHITE: begin
        a_d = a_q - e_w;
        b_d = b_q - o_w;
      end
      default: begin
        a_d = a_q;
        b_d = b_q;
      end
    endcase
  end

  // Block registers and the result register.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (cmd_i.ld_out) begin
      res_a_q <= a_q;
      res_b_q <= b_q;
    end
  end

  assign result_a_o = res_a_q;
  assign result_b_o = res_b_q;

endmodule

// File: rtl/core/rc5_checker.sv
// Port-level checker of the RC5 block cipher, bound to the top level.
// Depends on rc5_pkg and the assertion macros in rc5_block_cipher_defines.svh.
`include "rc5_block_cipher_defines.svh"

module rc5_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input rc5_pkg::word_t out_a_i,
  input rc5_pkg::word_t out_b_i
);
  import rc5_pkg::*;

  // Only one item is in work at a time.
  `RC5_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after accept")

  // A result never appears in the cycle after its item was accepted.
  `RC5_ASSERT_NOW(a_no_early_result, clk_i, rst_ni, $rose(out_valid_i), !$past(in_valid_i && in_ready_i), "result too early")

  // Handing a result to the output register frees the input side.
  `RC5_ASSERT_NOW(a_free_after_result, clk_i, rst_ni, $rose(out_valid_i), in_ready_i, "input not ready after result")

  // A stalled result holds its value.
  `RC5_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_a_i) && $stable(out_b_i), "stalled result changed")

endmodule

bind rc5_block_cipher rc5_checker u_rc5_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_in_i.valid),
  .in_ready_i  (item_in_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_a_i     (result_o.result_a),
  .out_b_i     (result_o.result_b)
);
